// ===== src/rdp_single_disk_recovery_engine_defines.svh =====
// ----------------------------------------------------------------------------
// RDP recovery engine assertion macros
// Shared assertion forms for the single-disk recovery engine, clocked on clk
// and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RDP_SINGLE_DISK_RECOVERY_ENGINE_DEFINES_SVH
`define RDP_SINGLE_DISK_RECOVERY_ENGINE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RDPSDR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RDPSDR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/rdpsdr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RDP recovery engine package
// Field widths, word formats, operation codes and state encodings shared by
// the recovery engine and its sub-blocks.
// ----------------------------------------------------------------------------
package rdpsdr_pkg;

  localparam int PRIME_W    = 5;
  localparam int DISK_W     = 5;
  localparam int ROW_W      = 4;
  localparam int WIDX_W     = 6;
  localparam int DATA_W     = 64;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  // Smallest prime that the code accepts; smaller settings act as this one.
  localparam logic [PRIME_W-1:0] MIN_PRIME = PRIME_W'(3);

  // Register indexes, taken from bit 2 of the byte address.
  localparam logic REG_PRIME  = 1'b0;
  localparam logic REG_FAILED = 1'b1;

  typedef enum logic [1:0] {
    MODE_PLAN = 2'd0,
    MODE_ACC  = 2'd1,
    MODE_READ = 2'd2,
    MODE_NOP  = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t               mode;
    logic [DISK_W-1:0]   disk;
    logic [ROW_W-1:0]    row;
    logic [WIDX_W-1:0]   word_index;
    logic [DATA_W-1:0]   data_word;
  } in_word_t;

  typedef struct packed {
    logic                row_used;
    logic [ROW_W-1:0]    row_target;
    logic                diag_used;
    logic [ROW_W-1:0]    diag_target;
    logic [DATA_W-1:0]   data_out;
    logic                ignored;
  } out_word_t;

  // Status of the failed-disk residue unit.
  typedef struct packed {
    logic               busy;
    logic [PRIME_W-1:0] rem;
  } mod_stat_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PLAN,
    ST_DECIDE,
    ST_READ,
    ST_WRITE,
    ST_DONE
  } top_state_t;

  typedef enum logic [1:0] {
    PL_IDLE,
    PL_RES,
    PL_MAP
  } plan_state_t;

endpackage

// ===== src/rdp_single_disk_recovery_engine.sv =====
`timescale 1ns / 1ps
`include "rdp_single_disk_recovery_engine_defines.svh"
// ----------------------------------------------------------------------------
// RDP single-disk recovery engine
// Rebuilds the blocks of one failed disk of a row-diagonal parity stripe by
// mixing row and diagonal recovery, folding surviving words into a buffer.
// ----------------------------------------------------------------------------
// After reset the engine sweeps its recovery buffer to zero, one word per
// cycle; no input word is taken during the sweep, although the configuration
// registers may be written. Every input word gives exactly one result word.
// Items are worked on one at a time around a single recovery buffer RAM with
// one read and one write port and a registered read: an accumulate reads and
// writes back the row-parity target and then the diagonal target; a read-out
// reads the word and writes zero back; a plan walks the residues and then the
// disks one per cycle. A finished result sits in the output register, so the
// next input word is taken while the previous result is still stalled. A
// configuration write starts a residue unit that reduces the failed disk
// modulo p by repeated subtraction; input is stalled until it is done.
// ----------------------------------------------------------------------------
module rdp_single_disk_recovery_engine #(
  parameter int MAX_PRIME       = 17,
  parameter int WORDS_PER_BLOCK = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rdpsdr_pkg::in_word_t                in_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output rdpsdr_pkg::out_word_t               out_word,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [rdpsdr_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [rdpsdr_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [rdpsdr_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                                cfg_pready
);
  import rdpsdr_pkg::*;

  // The prime register is five bits wide, which caps the usable prime.
  localparam int PRIME_CAP = (1 << PRIME_W) - 1;
  localparam int EFF_MAX   = (MAX_PRIME < PRIME_CAP) ? MAX_PRIME : PRIME_CAP;
  localparam int MT_N      = EFF_MAX - 1;
  localparam int MT_AW     = (MT_N > 1) ? $clog2(MT_N) : 1;
  localparam int BUF_ROWS  = MAX_PRIME - 1;
  localparam int BUF_DEPTH = BUF_ROWS * WORDS_PER_BLOCK;
  localparam int ADDR_W    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int WA_W      = (WORDS_PER_BLOCK > 1) ? $clog2(WORDS_PER_BLOCK) : 1;
  localparam int WIDX_N    = 1 << WIDX_W;

  // Configuration registers.
  logic [PRIME_W-1:0] prime_r, prime_nxt;
  logic [DISK_W-1:0]  fdisk_r, fdisk_nxt;
  logic               mod_go_r, mod_go_nxt;
  logic               cfg_wr;

  // Sequencer state.
  top_state_t         state_r, state_nxt;
  in_word_t           item_r, item_nxt;
  logic               pass_r, pass_nxt;
  logic               use0_r, use0_nxt;
  logic               use1_r, use1_nxt;
  logic               diag_ok_r, diag_ok_nxt;
  logic [PRIME_W-1:0] dt_r, dt_nxt;
  logic               ign_r, ign_nxt;
  logic [DATA_W-1:0]  dout_r, dout_nxt;
  logic [ADDR_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_r, out_nxt;

  logic [PRIME_W-1:0] p_eff;
  logic [PRIME_W-1:0] p_m1;
  mod_stat_t          mod_stat;
  logic               plan_busy;
  logic               plan_start;
  logic [MT_N-1:0]    method;
  logic [PRIME_W-1:0] mt_idx;
  logic               mt_bit;
  logic               in_acc;
  logic               out_load;
  logic               clr_last;

  // Decision path for an accumulate word.
  logic               dec_ign;
  logic               dec_row_ok;
  logic [PRIME_W:0]   dec_sum;
  logic [PRIME_W:0]   dec_enc;
  logic [PRIME_W:0]   dec_t;
  logic [PRIME_W:0]   dec_dt;

  // Buffer access.
  logic [WA_W-1:0]    wmod_tbl [WIDX_N];
  logic [PRIME_W-1:0] tgt_cur;
  logic [ADDR_W-1:0]  addr_cur;
  logic               use_rd;
  logic               use_wr;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [DATA_W-1:0]  ram_wdata;
  logic               ram_re;
  logic [DATA_W-1:0]  ram_rdata;

  // ---------------------------------------------------------------- config
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_FAILED) ? CFG_DATA_W'(fdisk_r)
                                                   : CFG_DATA_W'(prime_r);

  always_comb begin
    prime_nxt  = prime_r;
    fdisk_nxt  = fdisk_r;
    mod_go_nxt = cfg_wr;
    if (cfg_wr) begin
      if (cfg_paddr[2] == REG_PRIME) begin
        prime_nxt = cfg_pwdata[PRIME_W-1:0];
      end else begin
        fdisk_nxt = cfg_pwdata[DISK_W-1:0];
      end
    end
  end

  // Out-of-range primes are clamped; other values are used as they stand.
  assign p_eff = (prime_r < MIN_PRIME) ? MIN_PRIME :
                 ((32'(prime_r) > MAX_PRIME) ? PRIME_W'(MAX_PRIME) : prime_r);
  assign p_m1  = p_eff - PRIME_W'(1);

  // The residue is recomputed the cycle after any write, from the new values.
  rdpsdr_mod u_mod (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (mod_go_r),
    .prime       (p_eff),
    .failed_disk (fdisk_r),
    .stat        (mod_stat)
  );

  assign plan_start = in_acc && (in_word.mode == MODE_PLAN);

  rdpsdr_plan #(
    .MT_N  (MT_N),
    .RES_N (EFF_MAX)
  ) u_plan (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (plan_start),
    .prime       (p_eff),
    .residue     (mod_stat.rem),
    .failed_disk (fdisk_r),
    .busy        (plan_busy),
    .method      (method)
  );

  // ------------------------------------------------------------- handshake
  assign in_stall = (state_r != ST_IDLE) || mod_stat.busy || mod_go_r;
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  assign clr_last = (clr_cnt_r == ADDR_W'(BUF_DEPTH - 1));

  // One read of the method table per cycle: the word's own row while
  // deciding, the diagonal target while reading for the second pass.
  assign mt_idx = (state_r == ST_DECIDE) ? PRIME_W'(item_r.row) : dt_r;
  assign mt_bit = method[mt_idx[MT_AW-1:0]];

  // The word's disk plus row is below 2p, and so is the shifted diagonal,
  // so each reduction is one compare and subtract.
  assign dec_ign    = (item_r.disk == fdisk_r) || (item_r.disk > p_eff);
  assign dec_row_ok = !dec_ign && ({1'b0, item_r.row} < p_m1);
  assign dec_sum    = (PRIME_W + 1)'(item_r.disk) + (PRIME_W + 1)'(item_r.row);
  assign dec_enc    = (dec_sum >= {1'b0, p_eff}) ? dec_sum - {1'b0, p_eff} : dec_sum;
  assign dec_t      = dec_enc + {1'b0, p_eff} - {1'b0, mod_stat.rem};
  assign dec_dt     = (dec_t >= {1'b0, p_eff}) ? dec_t - {1'b0, p_eff} : dec_t;

  // Word index modulo the block length, as a table worked out at elaboration.
  for (genvar g = 0; g < WIDX_N; g++) begin : g_wmod
    localparam int WM = g % WORDS_PER_BLOCK;
    assign wmod_tbl[g] = WA_W'(WM);
  end

  assign tgt_cur  = pass_r ? dt_r : PRIME_W'(item_r.row);
  assign addr_cur = ADDR_W'(ADDR_W'(tgt_cur) * ADDR_W'(WORDS_PER_BLOCK))
                  + ADDR_W'(wmod_tbl[item_r.word_index]);
  assign use_rd   = pass_r ? (diag_ok_r && mt_bit) : use0_r;
  assign use_wr   = pass_r ? use1_r : use0_r;

  assign ram_re    = (state_r == ST_READ) && use_rd;
  assign ram_we    = (state_r == ST_CLEAR) || ((state_r == ST_WRITE) && use_wr);
  assign ram_waddr = (state_r == ST_CLEAR) ? clr_cnt_r : addr_cur;
  assign ram_wdata = ((state_r == ST_CLEAR) || (item_r.mode == MODE_READ))
                   ? '0 : (ram_rdata ^ item_r.data_word);

  rdpsdr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (BUF_DEPTH)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr_cur),
    .rdata (ram_rdata)
  );

  // ----------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_word.mode)
            MODE_PLAN: state_nxt = ST_PLAN;
            MODE_ACC,
            MODE_READ: state_nxt = ST_DECIDE;
            MODE_NOP:  state_nxt = ST_DONE;
            default:   state_nxt = ST_DONE;
          endcase
        end
      end
      ST_PLAN: begin
        if (!plan_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DECIDE: state_nxt = ST_READ;
      ST_READ:   state_nxt = ST_WRITE;
      ST_WRITE: begin
        if ((item_r.mode == MODE_ACC) && !pass_r) begin
          state_nxt = ST_READ;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // -------------------------------------------------------------- datapath
  always_comb begin
    item_nxt      = item_r;
    pass_nxt      = pass_r;
    use0_nxt      = use0_r;
    use1_nxt      = use1_r;
    diag_ok_nxt   = diag_ok_r;
    dt_nxt        = dt_r;
    ign_nxt       = ign_r;
    dout_nxt      = dout_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;

    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
      end
      ST_IDLE: begin
        if (in_acc) begin
          item_nxt    = in_word;
          pass_nxt    = 1'b0;
          use0_nxt    = 1'b0;
          use1_nxt    = 1'b0;
          diag_ok_nxt = 1'b0;
          dt_nxt      = '0;
          ign_nxt     = 1'b0;
          dout_nxt    = '0;
        end
      end
      ST_DECIDE: begin
        if (item_r.mode == MODE_ACC) begin
          ign_nxt     = dec_ign;
          use0_nxt    = dec_row_ok && !mt_bit && (item_r.disk < p_eff);
          // The diagonal that is not stored gives nothing.
          diag_ok_nxt = dec_row_ok && (dec_sum != {1'b0, p_m1})
                        && (dec_dt < {1'b0, p_m1});
          dt_nxt      = PRIME_W'(dec_dt);
        end else begin
          // Read-out beyond the stored rows returns zero.
          use0_nxt = (32'(item_r.row) < 32'(BUF_ROWS));
        end
      end
      ST_READ: begin
        if (pass_r) begin
          use1_nxt = diag_ok_r && mt_bit;
        end
      end
      ST_WRITE: begin
        if ((item_r.mode == MODE_READ) && use0_r) begin
          dout_nxt = ram_rdata;
        end
        if ((item_r.mode == MODE_ACC) && !pass_r) begin
          pass_nxt = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_nxt       = 1'b1;
          out_nxt.row_used    = use0_r && (item_r.mode == MODE_ACC);
          out_nxt.row_target  = (use0_r && (item_r.mode == MODE_ACC)) ? item_r.row : '0;
          out_nxt.diag_used   = use1_r;
          out_nxt.diag_target = use1_r ? dt_r[ROW_W-1:0] : '0;
          out_nxt.data_out    = dout_r;
          out_nxt.ignored     = ign_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prime_r     <= PRIME_W'(5);
      fdisk_r     <= '0;
      mod_go_r    <= 1'b0;
      state_r     <= ST_CLEAR;
      pass_r      <= 1'b0;
      use0_r      <= 1'b0;
      use1_r      <= 1'b0;
      diag_ok_r   <= 1'b0;
      ign_r       <= 1'b0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      prime_r     <= prime_nxt;
      fdisk_r     <= fdisk_nxt;
      mod_go_r    <= mod_go_nxt;
      state_r     <= state_nxt;
      pass_r      <= pass_nxt;
      use0_r      <= use0_nxt;
      use1_r      <= use1_nxt;
      diag_ok_r   <= diag_ok_nxt;
      ign_r       <= ign_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    dt_r   <= dt_nxt;
    dout_r <= dout_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // ------------------------------------------------------------ assertions
  `RDPSDR_ASSERT_SAME(a_ign_no_target, out_valid_r && out_r.ignored, !out_r.row_used && !out_r.diag_used, "ignored word reports a target")
  `RDPSDR_ASSERT_NEXT(a_done_loads, out_load, out_valid_r && (state_r == ST_IDLE), "finished item not presented")
  `RDPSDR_ASSERT_SAME(a_decide_residue, state_r == ST_DECIDE, !mod_stat.busy, "decision taken with residue pending")
  `RDPSDR_ASSERT_SAME(a_write_ctx, ram_we, (state_r == ST_CLEAR) || (state_r == ST_WRITE), "buffer written outside clear or write-back")

endmodule

// ===== src/rdpsdr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rdpsdr_ram #(
  parameter int  WIDTH = 64,
  parameter int  DEPTH = 1024,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/rdpsdr_mod.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Failed-disk residue unit
// Reduces the failed disk index modulo the effective prime by repeated
// subtraction, one subtraction per cycle.
// ----------------------------------------------------------------------------
module rdpsdr_mod (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [rdpsdr_pkg::PRIME_W-1:0] prime,
  input  logic [rdpsdr_pkg::DISK_W-1:0]  failed_disk,
  output rdpsdr_pkg::mod_stat_t        stat
);
  import rdpsdr_pkg::*;

  logic [PRIME_W-1:0] rem_r, rem_nxt;
  logic               busy_r, busy_nxt;

  always_comb begin
    rem_nxt  = rem_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = PRIME_W'(failed_disk);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_r >= prime) begin
        rem_nxt = rem_r - prime;
      end else begin
        busy_nxt = 1'b0;
      end
    end
  end

  // The reset failed disk is zero, whose residue is zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      rem_r  <= rem_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.rem  = rem_r;

endmodule

// ===== src/rdpsdr_plan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Recovery plan builder
// Marks the quadratic residues mod p one per cycle, then walks the disk
// indices one per cycle to set the rows that are recovered by diagonal.
// ----------------------------------------------------------------------------
module rdpsdr_plan #(
  parameter int MT_N  = 16,
  parameter int RES_N = 17
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [rdpsdr_pkg::PRIME_W-1:0] prime,
  input  logic [rdpsdr_pkg::PRIME_W-1:0] residue,
  input  logic [rdpsdr_pkg::DISK_W-1:0]  failed_disk,
  output logic                           busy,
  output logic [MT_N-1:0]                method
);
  import rdpsdr_pkg::*;

  localparam int MT_AW  = (MT_N > 1) ? $clog2(MT_N) : 1;
  localparam int RES_AW = (RES_N > 1) ? $clog2(RES_N) : 1;

  plan_state_t        state_r, state_nxt;
  logic [PRIME_W-1:0] i_r, i_nxt;
  logic [PRIME_W-1:0] sq_r, sq_nxt;
  logic [PRIME_W-1:0] v_r, v_nxt;
  logic               is_res_r, is_res_nxt;
  logic [RES_N-1:0]   res_r, res_nxt;
  logic [MT_N-1:0]    method_r, method_nxt;

  logic [PRIME_W-1:0] half;
  logic [PRIME_W-1:0] p_m1;
  logic [PRIME_W:0]   sq_sum;
  logic [PRIME_W-1:0] sq_step;
  logic [PRIME_W-1:0] v_step;
  logic               pick;

  assign p_m1    = prime - PRIME_W'(1);
  assign half    = p_m1 >> 1;
  // (i+1)^2 = i^2 + 2i + 1, and 2i + 1 never exceeds p here.
  assign sq_sum  = {1'b0, sq_r} + {i_r, 1'b1};
  assign sq_step = (sq_sum >= {1'b0, prime}) ? PRIME_W'(sq_sum - {1'b0, prime})
                                             : PRIME_W'(sq_sum);
  assign v_step  = (v_r == p_m1) ? '0 : v_r + PRIME_W'(1);
  assign pick    = is_res_r ? ~res_r[i_r[RES_AW-1:0]] : res_r[i_r[RES_AW-1:0]];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      PL_IDLE: begin
        if (start) begin
          state_nxt = PL_RES;
        end
      end
      PL_RES: begin
        if (i_r == half) begin
          state_nxt = PL_MAP;
        end
      end
      PL_MAP: begin
        if (i_r == p_m1) begin
          state_nxt = PL_IDLE;
        end
      end
      default: state_nxt = PL_IDLE;
    endcase
  end

  always_comb begin
    i_nxt      = i_r;
    sq_nxt     = sq_r;
    v_nxt      = v_r;
    is_res_nxt = is_res_r;
    res_nxt    = res_r;
    method_nxt = method_r;
    case (state_r)
      PL_IDLE: begin
        if (start) begin
          i_nxt      = PRIME_W'(1);
          sq_nxt     = PRIME_W'(1);
          is_res_nxt = 1'b0;
          res_nxt    = '0;
          method_nxt = '0;
        end
      end
      PL_RES: begin
        res_nxt[sq_r[RES_AW-1:0]] = 1'b1;
        if (PRIME_W'(failed_disk) == sq_r) begin
          is_res_nxt = 1'b1;
        end
        if (i_r == half) begin
          // The row of disk 1 is (p - e) mod p.
          i_nxt = PRIME_W'(1);
          v_nxt = (residue == '0) ? '0 : prime - residue;
        end else begin
          i_nxt  = i_r + PRIME_W'(1);
          sq_nxt = sq_step;
        end
      end
      PL_MAP: begin
        // Row p-1 does not exist, so it is never marked.
        if (pick && (v_r < p_m1)) begin
          method_nxt[v_r[MT_AW-1:0]] = 1'b1;
        end
        i_nxt = i_r + PRIME_W'(1);
        v_nxt = v_step;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= PL_IDLE;
      i_r      <= '0;
      sq_r     <= '0;
      v_r      <= '0;
      is_res_r <= 1'b0;
      res_r    <= '0;
      method_r <= '0;
    end else begin
      state_r  <= state_nxt;
      i_r      <= i_nxt;
      sq_r     <= sq_nxt;
      v_r      <= v_nxt;
      is_res_r <= is_res_nxt;
      res_r    <= res_nxt;
      method_r <= method_nxt;
    end
  end

  assign busy   = (state_r != PL_IDLE);
  assign method = method_r;

endmodule

// ===== bench/tb_rdp_single_disk_recovery_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RDP single-disk recovery engine testbench
// Drives plan, accumulate, read-out and idle words into the recovery engine
// under several code settings. A behavioural copy of the engine predicts every
// result word, and each result is checked field by field, in order.
// ----------------------------------------------------------------------------
module tb_rdp_single_disk_recovery_engine;
  import rdpsdr_pkg::*;

  localparam int MAX_P     = 17;
  localparam int WPB       = 64;
  localparam int LOST_ROWS = MAX_P - 1;
  // Cycles allowed for the last results to drain at the end of the run.
  localparam int DRAIN_LIMIT = 100000;

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  in_word_t              in_word     = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  out_word_t             out_word;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  rdp_single_disk_recovery_engine #(
    .MAX_PRIME       (MAX_P),
    .WORDS_PER_BLOCK (WPB)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // --------------------------------------------------------------------------
  // Behavioural copy of the engine. These mirror the two registers, the
  // per-row method table (1 = rebuild by diagonal parity) and the buffer in
  // which the lost rows are rebuilt, and are updated in the order in which
  // the engine accepts its input words.
  // --------------------------------------------------------------------------
  logic [PRIME_W-1:0]   prime_reg   = PRIME_W'(5);
  logic [DISK_W-1:0]    failed_reg  = '0;
  logic [LOST_ROWS-1:0] diag_method = '0;
  logic [DATA_W-1:0]    lost_words [LOST_ROWS*WPB];

  // Result words still owed by the engine, oldest first.
  out_word_t pending_rebuild_q[$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches     = 0;

  // Out-of-range primes are clamped into the range that the code supports;
  // a non-prime inside the range is simply used as it stands.
  function automatic int unsigned code_prime();
    if (prime_reg < MIN_PRIME) return MIN_PRIME;
    if (prime_reg > MAX_P) return MAX_P;
    return prime_reg;
  endfunction

  // Rebuilds the method table from the quadratic residues modulo p. When the
  // failed disk is itself a residue the non-residues select the diagonal rows,
  // otherwise the residues do. The residue test uses the raw failed disk
  // index, whereas the row mapping uses it reduced modulo p. A mapping onto
  // row p-1 is dropped, as that row does not exist in the stripe.
  function automatic void plan_methods();
    int unsigned      p;
    int unsigned      e;
    int unsigned      v;
    int unsigned      i;
    logic [MAX_P-1:0] is_residue;
    logic             failed_is_residue;
    p = code_prime();
    e = failed_reg % p;
    is_residue = '0;
    failed_is_residue = 1'b0;
    diag_method = '0;
    for (i = 1; i <= (p - 1) / 2; i++) begin
      v = (i * i) % p;
      is_residue[v] = 1'b1;
      if (failed_reg == v) failed_is_residue = 1'b1;
    end
    for (i = 1; i < p; i++) begin
      if (failed_is_residue ? !is_residue[i] : is_residue[i]) begin
        v = (i + 2 * p - e - 1) % p;
        if (v < p - 1) diag_method[v] = 1'b1;
      end
    end
  endfunction

  // Works out the result word for one accepted input word and updates the
  // mirrored state as the engine should.
  function automatic out_word_t predict_rebuild(input in_word_t w);
    out_word_t   r;
    int unsigned p;
    int unsigned e;
    int unsigned d;
    int unsigned rw;
    int unsigned wi;
    int unsigned dt;
    int unsigned a;
    r  = '0;
    p  = code_prime();
    e  = failed_reg % p;
    d  = w.disk;
    rw = w.row;
    wi = w.word_index % WPB;
    case (w.mode)
      MODE_PLAN: begin
        plan_methods();
      end
      MODE_ACC: begin
        // The failed disk itself and disks beyond the diagonal parity disk
        // are reported and otherwise ignored; rows outside the stripe do
        // nothing at all.
        if (w.disk == failed_reg || d > p) begin
          r.ignored = 1'b1;
        end else if (rw < p - 1) begin
          // Row parity covers disks 0..p-1 only, never the diagonal disk.
          if (!diag_method[rw] && d < p) begin
            r.row_used   = 1'b1;
            r.row_target = ROW_W'(rw);
            lost_words[rw * WPB + wi] ^= w.data_word;
          end
          // Words on the unstored diagonal help no lost row.
          if (d + rw != p - 1) begin
            dt = ((d + rw) % p + p - e) % p;
            if (dt < p - 1 && diag_method[dt]) begin
              r.diag_used   = 1'b1;
              r.diag_target = ROW_W'(dt);
              lost_words[dt * WPB + wi] ^= w.data_word;
            end
          end
        end
      end
      MODE_READ: begin
        if (rw < LOST_ROWS) begin
          a = rw * WPB + wi;
          r.data_out = lost_words[a];
          lost_words[a] = '0;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Clock, receiver stalls and result checking.
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver stalls at random, independently of what the sender does.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // A result word is taken at each edge where out_valid is high and out_stall
  // is low; both are read here as they stood just before the edge.
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rebuild_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result word at %0t ns: ru=%0d rt=%0d du=%0d dt=%0d data=%h ign=%0d",
                   $time, out_word.row_used, out_word.row_target, out_word.diag_used,
                   out_word.diag_target, out_word.data_out, out_word.ignored);
      end else begin
        want = pending_rebuild_q.pop_front();
        if (out_word.row_used !== want.row_used || out_word.row_target !== want.row_target ||
            out_word.diag_used !== want.diag_used ||
            out_word.diag_target !== want.diag_target ||
            out_word.data_out !== want.data_out || out_word.ignored !== want.ignored) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Result mismatch at %0t ns", $time);
            $display("  expected ru=%0d rt=%0d du=%0d dt=%0d data=%h ign=%0d",
                     want.row_used, want.row_target, want.diag_used, want.diag_target,
                     want.data_out, want.ignored);
            $display("  actual   ru=%0d rt=%0d du=%0d dt=%0d data=%h ign=%0d",
                     out_word.row_used, out_word.row_target, out_word.diag_used,
                     out_word.diag_target, out_word.data_out, out_word.ignored);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Shared stimulus helpers.
  // --------------------------------------------------------------------------
  function automatic logic [DATA_W-1:0] random_data();
    return {$urandom(), $urandom()};
  endfunction

  function automatic in_word_t make_word(input mode_t m, input int unsigned disk,
                                         input int unsigned row, input int unsigned wi,
                                         input logic [DATA_W-1:0] data);
    in_word_t w;
    w.mode       = m;
    w.disk       = DISK_W'(disk);
    w.row        = ROW_W'(row);
    w.word_index = WIDX_W'(wi);
    w.data_word  = data;
    return w;
  endfunction

  // Offers one input word and holds it until the engine takes it. Valid is
  // only lowered when the sender chooses to idle, so back-to-back words keep
  // in_valid high without it being lowered and raised in the same step.
  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pending_rebuild_q.push_back(predict_rebuild(w));
  endtask

  // Stops sending and waits until every owed result word has come back, which
  // leaves the engine idle as each input word gives exactly one result.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_rebuild_q.size() != 0) @(posedge clk);
  endtask

  // Two-phase register write. The upper data bits carry noise, which the
  // engine must discard.
  task automatic write_reg(input logic reg_idx, input logic [PRIME_W-1:0] value);
    logic [CFG_DATA_W-1:0] data;
    data = $urandom();
    data[PRIME_W-1:0] = value;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'({reg_idx, 2'b00});
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (cfg_pready !== 1'b1) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (reg_idx == REG_PRIME) prime_reg = value;
    else failed_reg = value;
  endtask

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Hand-picked words at the reset settings (p = 5, disk 0 failed), then with
  // a prime below the range and a failed disk beyond p, then with a prime
  // above the range.
  task automatic test_directed_cases();
    // An idle-mode word with every field at its top must change nothing.
    send_word(make_word(MODE_NOP, 31, 15, 63, '1));
    // Before any plan every row is rebuilt by row parity.
    send_word(make_word(MODE_ACC, 1, 0, 0, '1));
    send_word(make_word(MODE_PLAN, 0, 0, 0, '0));
    // The failed disk and a disk beyond the diagonal parity disk are ignored.
    send_word(make_word(MODE_ACC, 0, 1, 5, random_data()));
    send_word(make_word(MODE_ACC, 6, 1, 5, random_data()));
    send_word(make_word(MODE_ACC, 31, 15, 63, '1));
    // The diagonal parity disk feeds diagonal recovery only.
    send_word(make_word(MODE_ACC, 5, 1, 63, random_data()));
    // Row p-1 lies outside the stripe.
    send_word(make_word(MODE_ACC, 4, 4, 63, random_data()));
    // Disk 3 on row 1 lies on the unstored diagonal.
    send_word(make_word(MODE_ACC, 3, 1, 63, random_data()));
    send_word(make_word(MODE_ACC, 2, 2, 63, '0));
    send_word(make_word(MODE_ACC, 3, 0, 0, random_data()));
    // Read-outs return the rebuilt word and clear it; the second read of
    // row 0 must come back zero.
    send_word(make_word(MODE_READ, 31, 0, 0, '1));
    send_word(make_word(MODE_READ, 0, 1, 63, '0));
    send_word(make_word(MODE_READ, 0, 15, 63, random_data()));
    send_word(make_word(MODE_READ, 0, 0, 0, '0));

    // Prime 1 acts as 3; failed disk 7 is reduced modulo 3 for the mapping.
    drain();
    write_reg(REG_PRIME, PRIME_W'(1));
    write_reg(REG_FAILED, DISK_W'(7));
    // The method table stays as planned until the next plan word.
    send_word(make_word(MODE_ACC, 1, 1, 9, random_data()));
    send_word(make_word(MODE_PLAN, 31, 15, 63, '1));
    send_word(make_word(MODE_ACC, 1, 0, 9, random_data()));
    send_word(make_word(MODE_ACC, 3, 1, 9, random_data()));
    send_word(make_word(MODE_READ, 0, 0, 9, '0));

    // Prime 31 acts as 17, so disk 17 is the diagonal parity disk.
    drain();
    write_reg(REG_PRIME, PRIME_W'(31));
    write_reg(REG_FAILED, DISK_W'(16));
    send_word(make_word(MODE_PLAN, 0, 0, 0, '0));
    send_word(make_word(MODE_ACC, 17, 15, 63, '1));
    send_word(make_word(MODE_ACC, 0, 14, 0, random_data()));
    send_word(make_word(MODE_READ, 0, 15, 63, '0));
  endtask

  // One code setting: mostly accumulate and read-out words that fall inside
  // the stripe and share a few word positions, so that rebuilt rows build up
  // and are read back, with some fully random words mixed in as noise.
  task automatic random_phase(input int unsigned n_words, input logic [PRIME_W-1:0] prime,
                              input logic [DISK_W-1:0] failed, input bit pause_midway);
    int unsigned       p;
    int unsigned       n;
    int unsigned       pick;
    logic [WIDX_W-1:0] pool [4];
    in_word_t          w;
    drain();
    write_reg(REG_PRIME, prime);
    write_reg(REG_FAILED, failed);
    p = code_prime();
    foreach (pool[j]) pool[j] = WIDX_W'($urandom_range(WPB - 1));
    // Now and then the old plan is kept across the change of setting.
    if ($urandom_range(9) != 0)
      send_word(make_word(MODE_PLAN, $urandom_range(31), $urandom_range(15),
                          $urandom_range(63), random_data()));
    for (n = 0; n < n_words; n++) begin
      pick = $urandom_range(99);
      if (pick < 68)
        w = make_word(MODE_ACC, $urandom_range(p), $urandom_range(p - 2),
                      pool[$urandom_range(3)], random_data());
      else if (pick < 90)
        w = make_word(MODE_READ, $urandom_range(31), $urandom_range(p - 2),
                      pool[$urandom_range(3)], random_data());
      else
        w = make_word(mode_t'($urandom_range(3)), $urandom_range(31), $urandom_range(15),
                      $urandom_range(63), random_data());
      // Let the engine empty completely once in the middle of the phase.
      if (pause_midway && n == n_words / 2) drain();
      send_word(w);
    end
  endtask

  // Three idling patterns in turn, each over four code settings that include
  // the extremes of both registers, a non-prime and failed disks at p-1 and
  // beyond p.
  task automatic test_random_traffic();
    int unsigned        ph;
    int unsigned        k;
    logic [PRIME_W-1:0] primes  [12] = '{3, 17, 5, 31, 0, 7, 13, 9, 2, 11, 17, 3};
    logic [DISK_W-1:0]  faileds [12] = '{2, 16, 4, 31, 1, 6, 20, 5, 0, 3, 0, 1};
    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 18;
          recv_stall_pct = 56;
        end
        1: begin
          send_idle_pct  = 56;
          recv_stall_pct = 18;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (k = 0; k < 4; k++)
        random_phase(68, primes[ph * 4 + k], faileds[ph * 4 + k], k == 1);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence. Reset is held first; the engine then sweeps its
  // buffer to zero on its own and stalls input until that is done, which the
  // handshake absorbs.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned waited;
    foreach (lost_words[i]) lost_words[i] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct  = 18;
    recv_stall_pct = 56;
    test_directed_cases();
    test_random_traffic();

    // Wait for the last result words, then a short while longer so that any
    // stray extra word would still be seen.
    in_valid <= 1'b0;
    waited = 0;
    while (pending_rebuild_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (16) @(posedge clk);
    if (mismatches == 0 && pending_rebuild_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #3000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/rdpsdr_pkg.sv
src/rdpsdr_ram.sv
src/rdpsdr_mod.sv
src/rdpsdr_plan.sv
src/rdp_single_disk_recovery_engine.sv
bench/tb_rdp_single_disk_recovery_engine.sv
